### rtl/core/assert_macros.svh
// assertion macros shared by the histogram accumulator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define HBA_CHECK(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// same-cycle implication
`define HBA_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HBA_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/hba_pkg.sv
// shared types, codes and helpers of the histogram accumulator
package hba_pkg;

    localparam int MAX_BINS_DEF = 256;
    localparam int SUM_W        = 48;
    localparam int S_DATA_W     = 80;
    localparam int M_DATA_W     = 256;

    // command codes
    localparam logic [1:0] CMD_COLLECT = 2'd0;
    localparam logic [1:0] CMD_LOAD    = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;
    localparam logic [1:0] CMD_CLEAR   = 2'd3;

    // sample classes
    localparam logic [1:0] CLS_FINITE  = 2'd0;
    localparam logic [1:0] CLS_NEG_INF = 2'd1;
    localparam logic [1:0] CLS_POS_INF = 2'd2;
    localparam logic [1:0] CLS_INVALID = 2'd3;

    // result status and place codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_REJECT   = 2'd1;
    localparam logic [1:0] STAT_NOT_SET  = 2'd2;
    localparam logic [1:0] PLACE_BIN     = 2'd0;
    localparam logic [1:0] PLACE_UNDER   = 2'd1;
    localparam logic [1:0] PLACE_OVER    = 2'd2;

    typedef enum logic [2:0] {
        K_FINITE,
        K_NEG_INF,
        K_POS_INF,
        K_BAD_CLASS,
        K_LOAD,
        K_READ,
        K_CLEAR
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] value;
        logic [31:0]        weight;
        logic [8:0]         slot;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_LOAD_CMP,
        ST_BIN_RD,
        ST_DONE
    } st_t;

    // saturating add of a weight onto a sum
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [31:0] w);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W-31){1'b0}}, w};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

### rtl/core/hba_queue.sv
// two-entry queue of classified items between front and back
`include "assert_macros.svh"
module hba_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  hba_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output hba_pkg::item_t q_item
);

    hba_pkg::item_t store_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = store_reg[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    `HBA_CHECK(a_q_count_bound, cnt_reg <= 2'd2, "queue count above depth")
    `HBA_IMPLY(a_q_no_pop_empty, pop, cnt_reg != 2'd0, "pop from empty queue")
    `HBA_IMPLY(a_q_no_push_full, push, cnt_reg != 2'd2, "push into full queue")

endmodule

### rtl/core/hba_front.sv
// input side: takes beats and classifies them into queue items
module hba_front (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [hba_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [1:0]                   s_tuser,
    input  logic                         q_full,
    output logic                         push,
    output hba_pkg::item_t               push_item
);

    logic [1:0] cls;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;
    assign cls      = s_tdata[33:32];

    // classify command and sample class
    always_comb begin
        push_item.value  = s_tdata[31:0];
        push_item.weight = s_tdata[65:34];
        push_item.slot   = s_tdata[74:66];
        case (s_tuser)
            hba_pkg::CMD_COLLECT: begin
                case (cls)
                    hba_pkg::CLS_FINITE:  push_item.kind = hba_pkg::K_FINITE;
                    hba_pkg::CLS_NEG_INF: push_item.kind = hba_pkg::K_NEG_INF;
                    hba_pkg::CLS_POS_INF: push_item.kind = hba_pkg::K_POS_INF;
                    default:              push_item.kind = hba_pkg::K_BAD_CLASS;
                endcase
            end
            hba_pkg::CMD_LOAD:  push_item.kind = hba_pkg::K_LOAD;
            hba_pkg::CMD_READ:  push_item.kind = hba_pkg::K_READ;
            default:            push_item.kind = hba_pkg::K_CLEAR;
        endcase
    end

endmodule

### rtl/core/hba_back.sv
// back end: edge search, bin update and result register
`include "assert_macros.svh"
module hba_back #(
    parameter int MAX_BINS = hba_pkg::MAX_BINS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [8:0]                   cfg_wdata,
    input  logic                         q_valid,
    input  hba_pkg::item_t               q_item,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [hba_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int CNT_W   = $clog2(MAX_BINS + 2);
    localparam int EDGE_AW = $clog2(MAX_BINS + 1);
    localparam int BIN_AW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int SW      = hba_pkg::SUM_W;

    hba_pkg::st_t        state_reg, state_next;
    hba_pkg::item_t      item_reg, item_next;
    logic [CNT_W-1:0]    edges_reg, edges_next;
    logic [8:0]          biu_reg, biu_next;
    logic [CNT_W-1:0]    lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [CNT_W:0]      mid_sum;
    logic [BIN_AW-1:0]   bidx_reg, bidx_next;
    logic [1:0]          status_reg, status_next, place_reg, place_next;
    logic [SW-1:0]       btot_reg, btot_next;
    logic [SW-1:0]       under_reg, under_next, over_reg, over_next;
    logic [SW-1:0]       neg_reg, neg_next, pos_reg, pos_next;
    logic [MAX_BINS-1:0] vld_reg, vld_next;
    logic                out_valid_reg, out_valid_next;
    logic [hba_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;

    logic signed [31:0]  edge_mem [MAX_BINS+1];
    logic signed [31:0]  edge_rd_reg;
    logic [SW-1:0]       bin_mem [MAX_BINS];
    logic [SW-1:0]       bin_rd_reg;

    logic                edge_re, edge_we, bin_re, bin_we;
    logic [EDGE_AW-1:0]  edge_addr;
    logic [BIN_AW-1:0]   bin_addr;
    logic [SW-1:0]       bin_wdata, bin_cur, bin_sum;
    logic [CNT_W-1:0]    nb, nb_p1;
    logic                set_up;
    logic [7:0]          bnum_out;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // active bin count with range clamp
    always_comb begin
        if (biu_reg == 9'd0) begin
            nb = CNT_W'(1);
        end else if (32'(biu_reg) > 32'(MAX_BINS)) begin
            nb = CNT_W'(MAX_BINS);
        end else begin
            nb = CNT_W'(biu_reg);
        end
        nb_p1   = nb + CNT_W'(1);
        set_up  = (edges_reg == nb_p1);
        mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
        bin_cur = vld_reg[bidx_reg] ? bin_rd_reg : '0;
        bin_sum = hba_pkg::sat_add(bin_cur, item_reg.weight);
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        edges_next     = edges_reg;
        biu_next       = biu_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        bidx_next      = bidx_reg;
        status_next    = status_reg;
        place_next     = place_reg;
        btot_next      = btot_reg;
        under_next     = under_reg;
        over_next      = over_reg;
        neg_next       = neg_reg;
        pos_next       = pos_reg;
        vld_next       = vld_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        edge_re        = 1'b0;
        edge_we        = 1'b0;
        edge_addr      = EDGE_AW'(edges_reg);
        bin_re         = 1'b0;
        bin_we         = 1'b0;
        bin_addr       = bidx_reg;
        bin_wdata      = bin_sum;
        bnum_out       = 8'(bidx_reg);

        // config write only while no edge is loaded
        if (cfg_we && edges_reg == '0) begin
            biu_next = cfg_wdata;
        end

        case (state_reg)
            hba_pkg::ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    state_next = hba_pkg::ST_EXEC;
                end
            end
            hba_pkg::ST_EXEC: begin
                status_next = hba_pkg::STAT_OK;
                place_next  = hba_pkg::PLACE_BIN;
                btot_next   = '0;
                bidx_next   = '0;
                state_next  = hba_pkg::ST_DONE;
                case (item_reg.kind)
                    hba_pkg::K_NEG_INF: begin
                        neg_next   = hba_pkg::sat_add(neg_reg, item_reg.weight);
                        place_next = hba_pkg::PLACE_UNDER;
                    end
                    hba_pkg::K_POS_INF: begin
                        pos_next   = hba_pkg::sat_add(pos_reg, item_reg.weight);
                        place_next = hba_pkg::PLACE_OVER;
                    end
                    hba_pkg::K_BAD_CLASS: begin
                        status_next = hba_pkg::STAT_REJECT;
                    end
                    hba_pkg::K_FINITE: begin
                        if (!set_up) begin
                            status_next = hba_pkg::STAT_NOT_SET;
                        end else begin
                            lo_next    = '0;
                            hi_next    = edges_reg;
                            state_next = hba_pkg::ST_SRCH_RD;
                        end
                    end
                    hba_pkg::K_LOAD: begin
                        if (32'(item_reg.slot) != 32'(edges_reg) || edges_reg >= nb_p1) begin
                            status_next = hba_pkg::STAT_REJECT;
                        end else if (edges_reg == '0) begin
                            edge_we    = 1'b1;
                            edges_next = edges_reg + CNT_W'(1);
                        end else begin
                            edge_re    = 1'b1;
                            edge_addr  = EDGE_AW'(edges_reg - CNT_W'(1));
                            state_next = hba_pkg::ST_LOAD_CMP;
                        end
                    end
                    hba_pkg::K_READ: begin
                        if (!set_up) begin
                            status_next = hba_pkg::STAT_NOT_SET;
                        end else if (32'(item_reg.slot) >= 32'(nb)) begin
                            status_next = hba_pkg::STAT_REJECT;
                        end else begin
                            bidx_next  = BIN_AW'(item_reg.slot);
                            bin_re     = 1'b1;
                            bin_addr   = BIN_AW'(item_reg.slot);
                            state_next = hba_pkg::ST_BIN_RD;
                        end
                    end
                    default: begin
                        vld_next   = '0;
                        edges_next = '0;
                        under_next = '0;
                        over_next  = '0;
                        neg_next   = '0;
                        pos_next   = '0;
                    end
                endcase
            end
            hba_pkg::ST_SRCH_RD: begin
                if (lo_reg < hi_reg) begin
                    mid_next   = mid_sum[CNT_W:1];
                    edge_re    = 1'b1;
                    edge_addr  = EDGE_AW'(mid_sum[CNT_W:1]);
                    state_next = hba_pkg::ST_SRCH_CMP;
                end else if (lo_reg == '0) begin
                    under_next = hba_pkg::sat_add(under_reg, item_reg.weight);
                    place_next = hba_pkg::PLACE_UNDER;
                    state_next = hba_pkg::ST_DONE;
                end else if (lo_reg >= nb_p1) begin
                    over_next  = hba_pkg::sat_add(over_reg, item_reg.weight);
                    place_next = hba_pkg::PLACE_OVER;
                    state_next = hba_pkg::ST_DONE;
                end else begin
                    bidx_next  = BIN_AW'(lo_reg - CNT_W'(1));
                    bin_re     = 1'b1;
                    bin_addr   = BIN_AW'(lo_reg - CNT_W'(1));
                    state_next = hba_pkg::ST_BIN_RD;
                end
            end
            hba_pkg::ST_SRCH_CMP: begin
                if (edge_rd_reg <= item_reg.value) begin
                    lo_next = mid_reg + CNT_W'(1);
                end else begin
                    hi_next = mid_reg;
                end
                state_next = hba_pkg::ST_SRCH_RD;
            end
            hba_pkg::ST_LOAD_CMP: begin
                if (item_reg.value <= edge_rd_reg) begin
                    status_next = hba_pkg::STAT_REJECT;
                end else begin
                    edge_we    = 1'b1;
                    edges_next = edges_reg + CNT_W'(1);
                end
                state_next = hba_pkg::ST_DONE;
            end
            hba_pkg::ST_BIN_RD: begin
                if (item_reg.kind == hba_pkg::K_FINITE) begin
                    bin_we             = 1'b1;
                    vld_next[bidx_reg] = 1'b1;
                    btot_next          = bin_sum;
                end else begin
                    btot_next = bin_cur;
                end
                state_next = hba_pkg::ST_DONE;
            end
            hba_pkg::ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'b0, pos_reg, neg_reg, over_reg, under_reg,
                                      btot_reg, bnum_out, place_reg, status_reg};
                    state_next     = hba_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hba_pkg::ST_IDLE;
            end
        endcase
    end

    // control and sum registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= hba_pkg::ST_IDLE;
            edges_reg     <= '0;
            biu_reg       <= 9'd1;
            under_reg     <= '0;
            over_reg      <= '0;
            neg_reg       <= '0;
            pos_reg       <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            edges_reg     <= edges_next;
            biu_reg       <= biu_next;
            under_reg     <= under_next;
            over_reg      <= over_next;
            neg_reg       <= neg_next;
            pos_reg       <= pos_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working payload registers
    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        bidx_reg     <= bidx_next;
        status_reg   <= status_next;
        place_reg    <= place_next;
        btot_reg     <= btot_next;
        out_data_reg <= out_data_next;
    end

    // edge memory
    always_ff @(posedge aclk) begin
        if (edge_we) begin
            edge_mem[edge_addr] <= item_reg.value;
        end
        if (edge_re) begin
            edge_rd_reg <= edge_mem[edge_addr];
        end
    end

    // bin sum memory
    always_ff @(posedge aclk) begin
        if (bin_we) begin
            bin_mem[bin_addr] <= bin_wdata;
        end
        if (bin_re) begin
            bin_rd_reg <= bin_mem[bin_addr];
        end
    end

    `HBA_CHECK(a_edges_bound, 32'(edges_reg) <= 32'(MAX_BINS + 1), "edge count overrun")
    `HBA_IMPLY(a_search_window, state_reg == hba_pkg::ST_SRCH_CMP, mid_reg < hi_reg && lo_reg <= mid_reg, "search midpoint outside window")
    `HBA_NEXT(a_done_emits, state_reg == hba_pkg::ST_DONE && (!out_valid_reg || m_tready), out_valid_reg && state_reg == hba_pkg::ST_IDLE, "finished item not presented")

endmodule

### rtl/core/histogram_bin_accumulator.sv
// Weighted variable-edge histogram. Items settled in one step (infinities, rejects, not
// set up, clear, first edge) pass from ST_EXEC to ST_DONE; later edge loads add ST_LOAD_CMP
// and bin reads add ST_BIN_RD. A finite sample runs a binary search of ST_SRCH_RD and
// ST_SRCH_CMP steps, one read of the one-port edge memory per step, then ST_BIN_RD for a bin hit.
// The back end holds one item at a time; the two-entry queue takes beats while not full.
// Reset (synchronous, aresetn low) clears sums, valid bits, edge count, bin count to 1.
module histogram_bin_accumulator #(
    parameter int MAX_BINS = hba_pkg::MAX_BINS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [8:0]                   cfg_wdata,   // bins_in_use
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // sample_value[31:0], sample_class[33:32], sample_weight[65:34], slot_index[74:66]
    input  logic [hba_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [1:0]                   s_tuser,     // command[1:0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // status[1:0], hit_place[3:2], bin_number[11:4], bin_total[59:12],
    // under_total[107:60], over_total[155:108], neg_inf_total[203:156],
    // pos_inf_total[251:204]
    output logic [hba_pkg::M_DATA_W-1:0] m_tdata
);

    logic           q_full, push, pop, q_valid;
    hba_pkg::item_t push_item, q_item;

    // front: accept and classify
    hba_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // queue between the halves
    hba_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // back: search, update, result
    hba_back #(.MAX_BINS(MAX_BINS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### dv/histogram_bin_accumulator_test.sv
// self-checking testbench for the variable-edge weighted histogram accumulator
module histogram_bin_accumulator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  NBINS     = hba_pkg::MAX_BINS_DEF;
    localparam int  RAND_BEATS = 1600;
    localparam int  BURST_BEATS = 150;
    localparam longint CYCLE_LIMIT = 4_000_000;
    localparam logic [47:0] SUM_TOP = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [1:0]  status;
        logic [1:0]  place;
        logic [7:0]  bin_no;
        logic [47:0] bin_sum;
        logic [47:0] under_sum;
        logic [47:0] over_sum;
        logic [47:0] ninf_sum;
        logic [47:0] pinf_sum;
    } hist_result_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [8:0]                    cfg_wdata = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [hba_pkg::S_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]                    s_tuser = hba_pkg::CMD_COLLECT;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [hba_pkg::M_DATA_W-1:0]  m_tdata;

    // shadow histogram state
    logic signed [31:0] edge_vals [0:NBINS];
    int unsigned        edge_count;
    logic [47:0]        bin_acc [0:NBINS-1];
    logic [47:0]        under_acc, over_acc, ninf_acc, pinf_acc;
    logic [8:0]         bins_reg;

    hist_result_t pending_results[$];
    longint       cycle_count = 0;
    int           fail_count = 0;
    int           beats_sent = 0;
    bit           tx_gaps = 1'b1;
    bit           rx_stalls = 1'b1;

    histogram_bin_accumulator dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run-away guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side backpressure
    always @(negedge aclk) begin
        m_tready <= !rx_stalls || ($urandom_range(99) >= 37);
    end

    function automatic int unsigned bins_active();
        if (bins_reg == 0) return 1;
        if (bins_reg > NBINS) return NBINS;
        return bins_reg;
    endfunction

    function automatic logic [47:0] add_clip(logic [47:0] a, logic [31:0] w);
        logic [48:0] s;
        s = {1'b0, a} + {17'd0, w};
        return s[48] ? SUM_TOP : s[47:0];
    endfunction

    // predicts the result of one accepted beat and updates the shadow state
    function automatic void histogram_predict(logic [1:0] cmd, logic signed [31:0] val,
                                              logic [1:0] cls, logic [31:0] w,
                                              logic [8:0] slot);
        hist_result_t r;
        int unsigned nb, hits;
        bit set_up;
        nb = bins_active();
        set_up = (edge_count == nb + 1);
        r = '{default: '0};
        r.status = hba_pkg::STAT_OK;
        r.place = hba_pkg::PLACE_BIN;
        case (cmd)
            hba_pkg::CMD_COLLECT: begin
                if (cls == hba_pkg::CLS_NEG_INF) begin
                    ninf_acc = add_clip(ninf_acc, w);
                    r.place = hba_pkg::PLACE_UNDER;
                end else if (cls == hba_pkg::CLS_POS_INF) begin
                    pinf_acc = add_clip(pinf_acc, w);
                    r.place = hba_pkg::PLACE_OVER;
                end else if (cls != hba_pkg::CLS_FINITE) begin
                    r.status = hba_pkg::STAT_REJECT;
                end else if (!set_up) begin
                    r.status = hba_pkg::STAT_NOT_SET;
                end else begin
                    hits = 0;
                    for (int i = 0; i < edge_count; i++)
                        if (edge_vals[i] <= val) hits++;
                    if (hits == 0) begin
                        under_acc = add_clip(under_acc, w);
                        r.place = hba_pkg::PLACE_UNDER;
                    end else if (hits >= nb + 1) begin
                        over_acc = add_clip(over_acc, w);
                        r.place = hba_pkg::PLACE_OVER;
                    end else begin
                        bin_acc[hits-1] = add_clip(bin_acc[hits-1], w);
                        r.bin_no = 8'(hits - 1);
                        r.bin_sum = bin_acc[hits-1];
                    end
                end
            end
            hba_pkg::CMD_LOAD: begin
                if (slot != edge_count || edge_count >= nb + 1 ||
                    (edge_count > 0 && val <= edge_vals[edge_count-1])) begin
                    r.status = hba_pkg::STAT_REJECT;
                end else begin
                    edge_vals[edge_count] = val;
                    edge_count++;
                end
            end
            hba_pkg::CMD_READ: begin
                if (!set_up) r.status = hba_pkg::STAT_NOT_SET;
                else if (slot >= nb) r.status = hba_pkg::STAT_REJECT;
                else begin
                    r.bin_no = slot[7:0];
                    r.bin_sum = bin_acc[slot];
                end
            end
            default: begin
                foreach (bin_acc[i]) bin_acc[i] = '0;
                edge_count = 0;
                under_acc = '0;
                over_acc = '0;
                ninf_acc = '0;
                pinf_acc = '0;
            end
        endcase
        r.under_sum = under_acc;
        r.over_sum = over_acc;
        r.ninf_sum = ninf_acc;
        r.pinf_sum = pinf_acc;
        pending_results = {pending_results, r};
    endfunction

    // result checker
    always @(posedge aclk) begin
        hist_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                if (m_tdata[1:0] !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_tdata[1:0]);
                    fail_count++;
                end
                if (m_tdata[3:2] !== e.place) begin
                    $error("hit_place exp %0d got %0d", e.place, m_tdata[3:2]);
                    fail_count++;
                end
                if (m_tdata[11:4] !== e.bin_no) begin
                    $error("bin_number exp %0d got %0d", e.bin_no, m_tdata[11:4]);
                    fail_count++;
                end
                if (m_tdata[59:12] !== e.bin_sum) begin
                    $error("bin_total exp %0d got %0d", e.bin_sum, m_tdata[59:12]);
                    fail_count++;
                end
                if (m_tdata[107:60] !== e.under_sum) begin
                    $error("under_total exp %0d got %0d", e.under_sum, m_tdata[107:60]);
                    fail_count++;
                end
                if (m_tdata[155:108] !== e.over_sum) begin
                    $error("over_total exp %0d got %0d", e.over_sum, m_tdata[155:108]);
                    fail_count++;
                end
                if (m_tdata[203:156] !== e.ninf_sum) begin
                    $error("neg_inf_total exp %0d got %0d", e.ninf_sum, m_tdata[203:156]);
                    fail_count++;
                end
                if (m_tdata[251:204] !== e.pinf_sum) begin
                    $error("pos_inf_total exp %0d got %0d", e.pinf_sum, m_tdata[251:204]);
                    fail_count++;
                end
            end
        end
    end

    // drives one input beat and predicts its result once it is taken
    task automatic send_beat(logic [1:0] cmd, logic signed [31:0] val, logic [1:0] cls,
                             logic [31:0] w, logic [8:0] slot);
        @(negedge aclk);
        while (tx_gaps && $urandom_range(99) < 37) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {5'd0, slot, w, cls, val};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        histogram_predict(cmd, val, cls, w, slot);
        beats_sent++;
    endtask

    // sender pauses until every result is back and the block has settled
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_bins(logic [8:0] n);
        wait_drained();
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= n;
        @(posedge aclk);
        if (edge_count == 0) bins_reg = n;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // loads a strictly rising edge set for the active bin count, with some wrong-slot loads mixed in
    task automatic load_edges();
        int unsigned nb;
        longint cur, span;
        nb = bins_active();
        span = (64'd4294967295 - 64'd2000000) / (nb + 1);
        cur = -64'd2147483648 + $urandom_range(1000000);
        for (int i = 0; i <= nb; i++) begin
            if ($urandom_range(19) == 0)
                send_beat(hba_pkg::CMD_LOAD, 32'(cur), hba_pkg::CLS_FINITE, $urandom,
                          9'($urandom));
            send_beat(hba_pkg::CMD_LOAD, 32'(cur), hba_pkg::CLS_FINITE, $urandom, 9'(i));
            if ($urandom_range(19) == 0 && i > 0)
                send_beat(hba_pkg::CMD_LOAD, 32'(cur), hba_pkg::CLS_FINITE, $urandom,
                          9'(i + 1));
            cur = cur + 1 + ($urandom % span);
        end
    endtask

    // special cases and field extremes
    task automatic test_directed();
        send_beat(hba_pkg::CMD_READ, 32'sd0, hba_pkg::CLS_FINITE, 32'd0, 9'd0);
        send_beat(hba_pkg::CMD_COLLECT, 32'sd5, hba_pkg::CLS_FINITE, 32'd7, 9'd0);
        send_beat(hba_pkg::CMD_COLLECT, 32'sd0, hba_pkg::CLS_NEG_INF, 32'hFFFF_FFFF, 9'd0);
        send_beat(hba_pkg::CMD_COLLECT, 32'sd0, hba_pkg::CLS_POS_INF, 32'd0, 9'h1FF);
        send_beat(hba_pkg::CMD_COLLECT, 32'sd0, hba_pkg::CLS_INVALID, 32'd9, 9'd0);
        send_beat(hba_pkg::CMD_LOAD, 32'sd0, hba_pkg::CLS_FINITE, 32'd0, 9'd1);
        send_beat(hba_pkg::CMD_LOAD, 32'h8000_0000, hba_pkg::CLS_FINITE, 32'd0, 9'd0);
        send_beat(hba_pkg::CMD_LOAD, 32'h8000_0000, hba_pkg::CLS_FINITE, 32'd0, 9'd1);
        send_beat(hba_pkg::CMD_LOAD, 32'h7FFF_FFFF, hba_pkg::CLS_FINITE, 32'd0, 9'd1);
        send_beat(hba_pkg::CMD_LOAD, 32'h7FFF_FFFF, hba_pkg::CLS_FINITE, 32'd0, 9'd2);
        send_beat(hba_pkg::CMD_COLLECT, 32'h8000_0000, hba_pkg::CLS_FINITE, 32'hFFFF_FFFF,
                  9'd0);
        send_beat(hba_pkg::CMD_COLLECT, 32'h7FFF_FFFF, hba_pkg::CLS_FINITE, 32'd3, 9'd0);
        send_beat(hba_pkg::CMD_COLLECT, 32'h7FFF_FFFE, hba_pkg::CLS_FINITE, 32'd1, 9'd0);
        send_beat(hba_pkg::CMD_READ, 32'sd0, hba_pkg::CLS_FINITE, 32'd0, 9'd0);
        send_beat(hba_pkg::CMD_READ, 32'sd0, hba_pkg::CLS_FINITE, 32'd0, 9'd1);
        send_beat(hba_pkg::CMD_READ, 32'sd0, hba_pkg::CLS_FINITE, 32'd0, 9'h1FF);
        send_beat(hba_pkg::CMD_CLEAR, 32'sd0, hba_pkg::CLS_FINITE, 32'd0, 9'd0);
        send_beat(hba_pkg::CMD_READ, 32'sd0, hba_pkg::CLS_FINITE, 32'd0, 9'd0);
        write_bins(9'd0);
        send_beat(hba_pkg::CMD_LOAD, -32'sd10, hba_pkg::CLS_FINITE, 32'd0, 9'd0);
        send_beat(hba_pkg::CMD_LOAD, 32'sd10, hba_pkg::CLS_FINITE, 32'd0, 9'd1);
        send_beat(hba_pkg::CMD_COLLECT, -32'sd11, hba_pkg::CLS_FINITE, 32'd4, 9'd0);
        send_beat(hba_pkg::CMD_COLLECT, 32'sd10, hba_pkg::CLS_FINITE, 32'd2, 9'd0);
        send_beat(hba_pkg::CMD_COLLECT, -32'sd10, hba_pkg::CLS_FINITE, 32'd6, 9'd0);
        write_bins(9'd3);   // ignored, edges are loaded
        send_beat(hba_pkg::CMD_CLEAR, 32'sd0, hba_pkg::CLS_FINITE, 32'd0, 9'd0);
    endtask

    // long burst of heavy infinity samples with no idling on either side
    task automatic test_burst();
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        for (int i = 0; i < BURST_BEATS; i++)
            send_beat(hba_pkg::CMD_COLLECT, $urandom,
                      (i % 3 == 0) ? hba_pkg::CLS_NEG_INF : hba_pkg::CLS_POS_INF,
                      32'hFFFF_FFFF, 9'($urandom));
        send_beat(hba_pkg::CMD_CLEAR, 32'sd0, hba_pkg::CLS_FINITE, 32'd0, 9'd0);
        wait_drained();
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
    endtask

    // random bin sets, edge loads and mostly well-formed sample traffic
    task automatic test_random();
        int unsigned nb, j, ops, start;
        logic signed [31:0] v;
        logic [1:0] cls;
        int sel;
        start = beats_sent;
        for (int round = 0; beats_sent - start < RAND_BEATS; round++) begin
            send_beat(hba_pkg::CMD_CLEAR, $urandom, hba_pkg::CLS_FINITE, $urandom,
                      9'($urandom));
            case (round)
                1: write_bins(9'h1FF);
                2: write_bins(9'd256);
                3: write_bins(9'd0);
                default: write_bins((round % 9 == 5) ? 9'($urandom_range(9, 40))
                                                      : 9'($urandom_range(1, 8)));
            endcase
            tx_gaps = (round % 7 != 4);
            rx_stalls = (round % 7 != 4);
            load_edges();
            nb = bins_active();
            ops = $urandom_range(20, 60);
            for (int k = 0; k < ops; k++) begin
                sel = $urandom_range(99);
                if (sel < 75) begin
                    j = $urandom_range(nb);
                    v = $urandom_range(9) < 6 ? edge_vals[j] + $signed($urandom_range(2)) - 1
                                              : $signed($urandom);
                    case ($urandom_range(19))
                        0: cls = hba_pkg::CLS_NEG_INF;
                        1: cls = hba_pkg::CLS_POS_INF;
                        2: cls = hba_pkg::CLS_INVALID;
                        default: cls = hba_pkg::CLS_FINITE;
                    endcase
                    send_beat(hba_pkg::CMD_COLLECT, v, cls, pick_weight(), 9'($urandom));
                end else if (sel < 92) begin
                    send_beat(hba_pkg::CMD_READ, $urandom, 2'($urandom), $urandom,
                              $urandom_range(4) == 0 ? 9'($urandom) : 9'($urandom_range(nb)));
                end else begin
                    send_beat(hba_pkg::CMD_LOAD, $urandom, 2'($urandom), $urandom,
                              9'($urandom_range(nb + 1)));
                end
            end
        end
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
    endtask

    initial begin
        edge_count = 0;
        foreach (bin_acc[i]) bin_acc[i] = '0;
        foreach (edge_vals[i]) edge_vals[i] = '0;
        under_acc = '0;
        over_acc = '0;
        ninf_acc = '0;
        pinf_acc = '0;
        bins_reg = 9'd1;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_burst();
        test_random();
        wait_drained();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
